### rtl/core/bmhq_pkg.sv
package bmhq_pkg;

   // Signed key as held in the heap and carried on both channels
   typedef logic signed [31:0] key_type;

   // Request kind carried in req_type
   typedef enum logic {
      REQ_INSERT  = 1'b0,
      REQ_EXTRACT = 1'b1
   } req_kind_type;

   // Result status
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

### rtl/core/bmhq_req_if.sv
interface bmhq_req_if import bmhq_pkg::*; ();
   logic         valid;
   logic         ready;
   req_kind_type req_type;
   key_type      key;

   modport source (output valid, output req_type, output key, input ready);
   modport sink   (input valid, input req_type, input key, output ready);
endinterface

### rtl/core/bmhq_rsp_if.sv
interface bmhq_rsp_if import bmhq_pkg::*; ();
   logic       valid;
   logic       ready;
   key_type    min_value;
   status_type status;
   logic       now_empty;

   modport source (output valid, output min_value, output status, output now_empty,
                   input ready);
   modport sink   (input valid, input min_value, input status, input now_empty,
                   output ready);
endinterface

### rtl/core/binary_min_heap_queue.sv
// Ascending priority queue on a binary min-heap of signed 32-bit keys.
// req_bus takes one item per request: req_type selects insert (key is stored)
// or extract (the smallest key is removed). rsp_bus returns exactly one item
// per request: min_value (the extracted key, else 0), status (ok, extract on
// empty heap, insert on full heap dropped) and now_empty.
// The heap lives in one synchronous memory with two read ports and one write
// port. The key being moved is held in a register, so each level of a sift
// is a read state followed by a compare-and-write state.
// One request is in work at a time; the next can be accepted in the same
// cycle in which the result appears.
// A finished result waits in an output register; a new request is accepted
// while it waits, but a second result holds until the receiver takes the
// first, so a stalled receiver stops the queue after one more request.
// Reset (synchronous, active high) empties the heap at once: the entry count
// goes to zero and no memory clearing pass is needed.
module binary_min_heap_queue import bmhq_pkg::*; #(
   parameter int HEAP_DEPTH = 64
) (
   input logic         clock,
   input logic         reset,
   bmhq_req_if.sink    req_bus,
   bmhq_rsp_if.source  rsp_bus
);

   localparam int IDX_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
   localparam int CH_W  = IDX_W + 2;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_UP_CHK  = 7'b0000010,
      ST_UP_CMP  = 7'b0000100,
      ST_EX_LOAD = 7'b0001000,
      ST_DN_CHK  = 7'b0010000,
      ST_DN_CMP  = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   // Heap storage
   key_type heap_mem [HEAP_DEPTH];

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   key_type          key_ff, key_in;
   key_type          minv_ff, minv_in;
   status_type       stat_ff, stat_in;
   key_type          rd_a_ff, rd_b_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   key_type          rsp_min_ff, rsp_min_in;
   status_type       rsp_stat_ff, rsp_stat_in;
   logic             rsp_empty_ff, rsp_empty_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   key_type          wr_data;
   logic [IDX_W-1:0] rd_addr_a, rd_addr_b;

   logic [IDX_W-1:0] par_idx, last_idx;
   logic [CH_W-1:0]  lc_w, rc_w;
   logic             lc_ok, rc_ok, l_lt, r_lt_k, r_lt_l, pick_r;
   logic             req_fire;

   assign req_fire = req_bus.valid && req_bus.ready;
   // Take nothing while reset is held
   assign req_bus.ready = (state_ff == ST_IDLE) && !reset;

   // Heap index arithmetic
   assign par_idx  = (pos_ff - IDX_W'(1)) >> 1;
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign lc_w     = {1'b0, pos_ff, 1'b1};
   assign rc_w     = {1'b0, pos_ff, 1'b0} + CH_W'(2);
   assign lc_ok    = lc_w < CH_W'(count_ff);
   assign rc_ok    = rc_w < CH_W'(count_ff);

   // Child compares run side by side; the left child wins ties
   assign l_lt   = lc_ok && (rd_a_ff < key_ff);
   assign r_lt_k = rd_b_ff < key_ff;
   assign r_lt_l = rd_b_ff < rd_a_ff;
   assign pick_r = rc_ok && (l_lt ? r_lt_l : r_lt_k);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      minv_in      = minv_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_min_in   = rsp_min_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_empty_in = rsp_empty_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = key_ff;
      rd_addr_a    = par_idx;
      rd_addr_b    = rc_w[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               minv_in = '0;
               stat_in = STATUS_OK;
               if (req_bus.req_type == REQ_INSERT) begin
                  if (count_ff == CNT_W'(HEAP_DEPTH)) begin
                     // Drop the key: heap is full
                     stat_in  = STATUS_FULL;
                     state_in = ST_DONE;
                  end else begin
                     // Open a hole after the last entry
                     key_in   = req_bus.key;
                     pos_in   = IDX_W'(count_ff);
                     count_in = count_ff + CNT_W'(1);
                     state_in = ST_UP_CHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     stat_in  = STATUS_EMPTY;
                     state_in = ST_DONE;
                  end else begin
                     // Fetch root and last entry together
                     rd_addr_a = '0;
                     rd_addr_b = last_idx;
                     count_in  = count_ff - CNT_W'(1);
                     state_in  = ST_EX_LOAD;
                  end
               end
            end
         end

         ST_UP_CHK: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_addr_a = par_idx;
               state_in  = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (key_ff < rd_a_ff) begin
               // Pull the parent down into the hole and climb
               wr_data  = rd_a_ff;
               pos_in   = par_idx;
               state_in = ST_UP_CHK;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_EX_LOAD: begin
            minv_in  = rd_a_ff;
            key_in   = rd_b_ff;
            pos_in   = '0;
            state_in = ST_DN_CHK;
         end

         ST_DN_CHK: begin
            if (!lc_ok) begin
               // Leaf reached; skip the write once the heap has emptied
               wr_en    = CH_W'(pos_ff) < CH_W'(count_ff);
               state_in = ST_DONE;
            end else begin
               rd_addr_a = lc_w[IDX_W-1:0];
               rd_addr_b = rc_w[IDX_W-1:0];
               state_in  = ST_DN_CMP;
            end
         end

         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (pick_r) begin
               wr_data  = rd_b_ff;
               pos_in   = rc_w[IDX_W-1:0];
               state_in = ST_DN_CHK;
            end else if (l_lt) begin
               wr_data  = rd_a_ff;
               pos_in   = lc_w[IDX_W-1:0];
               state_in = ST_DN_CHK;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // Hold the result until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = minv_ff;
               rsp_stat_in  = stat_ff;
               rsp_empty_in = (count_ff == '0);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      minv_ff      <= minv_in;
      stat_ff      <= stat_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.min_value = rsp_min_ff;
   assign rsp_bus.status    = rsp_stat_ff;
   assign rsp_bus.now_empty = rsp_empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HEAP_DEPTH))
      else $error("entry count above heap depth");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CH_W'(wr_addr) < CH_W'(count_ff)))
      else $error("heap write outside live entries");

   a_extract_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EX_LOAD) |-> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("extract did not shrink the heap by one");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result item raised outside completion");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top import bmhq_pkg::*; ();

   localparam int HEAP_DEPTH  = 64;
   // Worst correct quiet stretch is the long receiver hold plus one item's sift
   // and a sender gap; allow a wide margin on top.
   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD   = 300;
   // Margin for the block to finish its last item before the run closes.
   localparam int TAIL_CYCLES = 40;

   typedef struct {
      key_type    min_value;
      status_type status;
      logic       now_empty;
   } heap_result_type;

   logic clock = 1'b0;
   logic reset;

   bmhq_req_if req_bus ();
   bmhq_rsp_if rsp_bus ();

   binary_min_heap_queue #(
      .HEAP_DEPTH(HEAP_DEPTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5ns clock = ~clock;

   // Shadow heap, kept in the same array layout as the block's store
   key_type         heap_model [HEAP_DEPTH];
   int              heap_fill = 0;
   heap_result_type pending_results [$];
   int              error_count = 0;
   int              burst_left = 0;
   // Toggle to ask the receiver for one long hold-off
   logic            hold_ask = 1'b0;

   // Apply one request to the shadow heap and return the item it must produce.
   // Sifts move a hole rather than swapping; the outcome is the same.
   function automatic heap_result_type predict_heap_request(req_kind_type kind, key_type key);
      heap_result_type res;
      key_type         moved;
      key_type         pick_val;
      int              pos;
      int              left;
      int              pick;
      bit              settled;
      res.min_value = '0;
      res.status    = STATUS_OK;
      if (kind == REQ_INSERT) begin
         if (heap_fill >= HEAP_DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            pos = heap_fill;
            heap_fill++;
            // climb only while strictly smaller than the parent
            while (pos > 0 && key < heap_model[(pos - 1) / 2]) begin
               heap_model[pos] = heap_model[(pos - 1) / 2];
               pos = (pos - 1) / 2;
            end
            heap_model[pos] = key;
         end
      end else if (heap_fill == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.min_value = heap_model[0];
         heap_fill--;
         moved   = heap_model[heap_fill];
         pos     = 0;
         settled = 1'b0;
         while (!settled) begin
            left     = 2 * pos + 1;
            pick     = pos;
            pick_val = moved;
            // left child first, so it wins a tie with the right
            if (left < heap_fill && heap_model[left] < pick_val) begin
               pick     = left;
               pick_val = heap_model[left];
            end
            if (left + 1 < heap_fill && heap_model[left + 1] < pick_val)
               pick = left + 1;
            if (pick == pos) begin
               settled = 1'b1;
            end else begin
               heap_model[pos] = heap_model[pick];
               pos = pick;
            end
         end
         heap_model[pos] = moved;
      end
      res.now_empty = (heap_fill == 0);
      return res;
   endfunction

   // Offer one item, in bursts with idle gaps between them. Called and
   // returning on a rising edge; valid stays high between items of a burst.
   task automatic send_request(req_kind_type kind, key_type key);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
      end
      burst_left--;
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.key      <= key;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_results = {pending_results, predict_heap_request(kind, key)};
   endtask

   // Drop valid and hold until every expected item has come back.
   // Always advance at least one edge so valid is not driven twice in a step.
   task automatic wait_for_results;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Mostly full-range keys; some extremes and a narrow band to force ties
   function automatic key_type random_key;
      key_type k;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       k = key_type'(32'h7fff_ffff);
               1:       k = key_type'(32'h8000_0000);
               2:       k = '0;
               default: k = '1;
            endcase
         end
         1, 2, 3: k = key_type'($urandom_range(0, 16)) - key_type'(8);
         default: k = key_type'($urandom);
      endcase
      return k;
   endfunction

   // Extract on an empty heap; the key field must not matter
   task automatic test_empty_extract;
      send_request(REQ_EXTRACT, key_type'(32'h7fff_ffff));
      send_request(REQ_EXTRACT, key_type'(32'h8000_0000));
      wait_for_results();
   endtask

   // Insert one key and take it straight back, so the heap empties each time
   task automatic test_single_entry;
      send_request(REQ_INSERT, key_type'(32'h8000_0000));
      send_request(REQ_EXTRACT, '0);
      send_request(REQ_INSERT, key_type'(32'h7fff_ffff));
      send_request(REQ_EXTRACT, '1);
      send_request(REQ_INSERT, '0);
      send_request(REQ_EXTRACT, '0);
      wait_for_results();
   endtask

   // Extreme keys and equal keys, then drain past empty
   task automatic test_extremes_and_ties;
      send_request(REQ_INSERT, key_type'(32'h7fff_ffff));
      send_request(REQ_INSERT, '1);
      send_request(REQ_INSERT, '0);
      send_request(REQ_INSERT, key_type'(32'h8000_0000));
      send_request(REQ_INSERT, key_type'(1));
      send_request(REQ_INSERT, key_type'(5));
      send_request(REQ_INSERT, key_type'(5));
      send_request(REQ_INSERT, '1);
      repeat (9) send_request(REQ_EXTRACT, '0);
      wait_for_results();
   endtask

   // Fill to capacity under a long receiver hold, refuse further inserts,
   // then empty the heap completely and once more
   task automatic test_full_heap;
      for (int i = 0; i < HEAP_DEPTH; i++) begin
         if (i == 8)
            hold_ask <= ~hold_ask;
         send_request(REQ_INSERT, random_key());
      end
      send_request(REQ_INSERT, key_type'(32'h8000_0000));
      send_request(REQ_INSERT, key_type'($urandom));
      repeat (HEAP_DEPTH + 1) send_request(REQ_EXTRACT, key_type'($urandom));
      wait_for_results();
   endtask

   // Phases with different insert bias walk the fill level across its range,
   // reaching both the full and the empty boundary
   task automatic test_random_traffic;
      int insert_pct;
      for (int phase = 0; phase < 10; phase++) begin
         case ($urandom_range(0, 4))
            0:       insert_pct = 85;
            1:       insert_pct = 60;
            2:       insert_pct = 50;
            3:       insert_pct = 40;
            default: insert_pct = 15;
         endcase
         for (int n = 0; n < 100; n++) begin
            send_request(req_kind_type'(($urandom_range(1, 100) <= insert_pct) ?
                                        REQ_INSERT : REQ_EXTRACT),
                         random_key());
         end
         if (phase == 4)
            wait_for_results();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_INSERT;
      req_bus.key      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_extract();
      test_single_entry();
      test_extremes_and_ties();
      test_full_heap();
      test_random_traffic();

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // Receiver: take result items on a random ready pattern, check each against
   // the oldest expectation, and honour a long hold-off when asked
   initial begin : rsp_side
      int              mode_left = 0;
      int              ready_pct = 100;
      int              hold_left = 0;
      logic            hold_seen = 1'b0;
      heap_result_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected item, expected none, actual min_value %0d status %0d",
                        $time, rsp_bus.min_value, rsp_bus.status);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.min_value !== want.min_value) begin
                  error_count++;
                  $display("%0t: min_value expected %0d actual %0d",
                           $time, want.min_value, rsp_bus.min_value);
               end
               if (rsp_bus.status !== want.status) begin
                  error_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_bus.status);
               end
               if (rsp_bus.now_empty !== want.now_empty) begin
                  error_count++;
                  $display("%0t: now_empty expected %0b actual %0b",
                           $time, want.now_empty, rsp_bus.now_empty);
               end
            end
         end
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = LONG_HOLD;
         end
         // pick a fresh stall pattern now and then; half the time none at all
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
               0, 1:    ready_pct = 100;
               2:       ready_pct = 50;
               default: ready_pct = 20;
            endcase
         end
         mode_left--;
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   // Watchdog: end the run if neither side moves an item for too long
   initial begin : watchdog
      int quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_top: errors");
      $finish;
   end

endmodule
